### hw/rtl/rtpc_pkg.sv
// Shared types and constants for the transition payload checker.
// No dependencies; used by the parser, the top level and the testbench.

package rtpc_pkg;

	localparam int unsigned FRAME_COUNT_DEF = 4;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned DIM_W      = 16;
	localparam int unsigned FRAME_SZ_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	typedef enum logic [4:0] {
		PH_FRAME_HDR = 5'b00001,
		PH_ROW_HDR   = 5'b00010,
		PH_TOKEN     = 5'b00100,
		PH_SKIP      = 5'b01000,
		PH_DONE      = 5'b10000
	} rtpc_phase_t;

	// one byte beat handed from the input stage to the parser
	typedef struct packed {
		logic              take;
		logic              last;
		logic [DATA_W-1:0] data;
	} rtpc_beat_t;

endpackage

### hw/rtl/rle_transition_payload_checker_unit.sv
// Pipeline: a beat is registered in the input register at acceptance and parsed when it
// advances out of it; the verdict for the last beat is then registered in the output register.
// Throughput: one byte beat per cycle; a last beat waits in the input register only
// while the previous verdict is not taken.
// Reset: arst_n clears all parse state and both valid flags; frame_width and
// frame_height return to 1. Depends on rtpc_pkg and rtpc_parser.

module rle_transition_payload_checker_unit #(
	parameter int unsigned FRAME_COUNT = rtpc_pkg::FRAME_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rtpc_pkg::DATA_W-1:0]        data_byte,
	input  logic                               is_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               payload_valid,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtpc_pkg::DIM_W-1:0]         cfg_data
);

	logic                          valid_s1;
	logic                          last_s1;
	logic [rtpc_pkg::DATA_W-1:0]   data_s1;
	logic                          advance;
	logic                          ok;
	logic [rtpc_pkg::DIM_W-1:0]    width_q;
	logic [rtpc_pkg::DIM_W-1:0]    height_q;
	logic                          out_valid_q;
	logic                          result_q;
	rtpc_pkg::rtpc_beat_t          beat;

	// a non-last beat never needs the output slot
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtpc_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				rtpc_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		beat.take = advance;
		beat.last = last_s1;
		beat.data = data_s1;
	end

	rtpc_parser #(
		.FRAME_COUNT(FRAME_COUNT)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (beat),
		.frame_width  (width_q),
		.frame_height (height_q),
		.ok           (ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			result_q <= ok;
	end

	assign out_valid     = out_valid_q;
	assign payload_valid = result_q;

endmodule

### hw/rtl/rtpc_parser.sv
// Byte-wise structure parser: frame/row headers, tokens, skips, sticky error.
// Depends on rtpc_pkg. Updates its state once per taken beat.

module rtpc_parser #(
	parameter int unsigned FRAME_COUNT = rtpc_pkg::FRAME_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtpc_pkg::rtpc_beat_t         beat,
	input  logic [rtpc_pkg::DIM_W-1:0]   frame_width,
	input  logic [rtpc_pkg::DIM_W-1:0]   frame_height,
	output logic                         ok
);

	localparam int unsigned FW = $clog2(FRAME_COUNT + 1);

	rtpc_pkg::rtpc_phase_t              phase_q, n_phase;
	logic [23:0]                        shift_q, n_shift;
	logic [1:0]                         hcnt_q, n_hcnt;
	logic [FW-1:0]                      frames_q, n_frames;
	logic [rtpc_pkg::FRAME_SZ_W-1:0]    fbl_q, n_fbl;
	logic [rtpc_pkg::DIM_W-1:0]         rows_q, n_rows;
	logic [rtpc_pkg::DIM_W-1:0]         rbl_q, n_rbl;
	logic [rtpc_pkg::DIM_W-1:0]         pix_q, n_pix;
	logic                               err_q, n_err;

	always_comb begin
		logic [rtpc_pkg::DATA_W-1:0]  b;
		logic [rtpc_pkg::DIM_W-1:0]   row_len;
		logic                         do_token;
		logic                         do_row;
		b        = beat.data;
		row_len  = '0;
		do_token = 1'b0;
		do_row   = 1'b0;
		n_phase  = phase_q;
		n_shift  = shift_q;
		n_hcnt   = hcnt_q;
		n_frames = frames_q;
		n_fbl    = fbl_q;
		n_rows   = rows_q;
		n_rbl    = rbl_q;
		n_pix    = pix_q;
		n_err    = err_q;

		if (!err_q) begin
			unique case (phase_q)
				rtpc_pkg::PH_FRAME_HDR: begin
					n_hcnt = 2'(hcnt_q + 2'd1);
					case (hcnt_q)
						2'd0: n_shift[7:0]   = b;
						2'd1: n_shift[15:8]  = b;
						2'd2: n_shift[23:16] = b;
						default: begin
							n_fbl   = {b, shift_q};
							n_shift = '0;
							n_rows  = '0;
							do_row  = 1'b1;
						end
					endcase
				end
				rtpc_pkg::PH_ROW_HDR: begin
					if (fbl_q == '0) begin
						n_err = 1'b1;
					end else begin
						n_fbl = fbl_q - 32'd1;
						if (!hcnt_q[0]) begin
							n_shift[7:0] = b;
							n_hcnt       = 2'd1;
						end else begin
							row_len = {b, shift_q[7:0]};
							n_rbl   = row_len;
							n_shift = '0;
							n_hcnt  = '0;
							if ({16'd0, row_len} > n_fbl) begin
								n_err = 1'b1;
							end else begin
								n_pix    = frame_width;
								do_token = 1'b1;
							end
						end
					end
				end
				rtpc_pkg::PH_TOKEN: begin
					if (rbl_q == '0 || fbl_q == '0) begin
						n_err = 1'b1;
					end else begin
						n_rbl = rbl_q - 16'd1;
						n_fbl = fbl_q - 32'd1;
						if (b != '0) begin
							if (pix_q != '0)
								n_pix = pix_q - 16'd1;
							do_token = 1'b1;
						end else if (n_rbl == '0) begin
							n_err = 1'b1;   // zero token with no room for its skip
						end else begin
							n_phase = rtpc_pkg::PH_SKIP;
						end
					end
				end
				rtpc_pkg::PH_SKIP: begin
					if (rbl_q == '0 || fbl_q == '0) begin
						n_err = 1'b1;
					end else begin
						n_rbl = rbl_q - 16'd1;
						n_fbl = fbl_q - 32'd1;
						if (b == '0 || {8'd0, b} > pix_q) begin
							n_err = 1'b1;
						end else begin
							n_pix    = pix_q - {8'd0, b};
							do_token = 1'b1;
						end
					end
				end
				default: n_err = 1'b1;   // data past the last frame
			endcase
		end

		// end of row check after a header, token or skip
		if (do_token) begin
			if (n_rbl == '0) begin
				n_rows = 16'(n_rows + 16'd1);
				do_row = 1'b1;
			end else if (n_pix == '0) begin
				n_err = 1'b1;
			end else begin
				n_phase = rtpc_pkg::PH_TOKEN;
			end
		end

		// end of frame check
		if (do_row) begin
			if (n_rows >= frame_height) begin
				if (n_fbl != '0) begin
					n_err = 1'b1;
				end else begin
					n_frames = FW'(n_frames + FW'(1));
					n_phase  = (n_frames >= FW'(FRAME_COUNT)) ? rtpc_pkg::PH_DONE
					                                          : rtpc_pkg::PH_FRAME_HDR;
				end
			end else begin
				n_phase = rtpc_pkg::PH_ROW_HDR;
			end
		end
	end

	assign ok = !n_err && (n_phase == rtpc_pkg::PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rtpc_pkg::PH_FRAME_HDR;
			shift_q  <= '0;
			hcnt_q   <= '0;
			frames_q <= '0;
			fbl_q    <= '0;
			rows_q   <= '0;
			rbl_q    <= '0;
			pix_q    <= '0;
			err_q    <= 1'b0;
		end else if (beat.take) begin
			if (beat.last) begin
				// payload closed: start over for the next one
				phase_q  <= rtpc_pkg::PH_FRAME_HDR;
				shift_q  <= '0;
				hcnt_q   <= '0;
				frames_q <= '0;
				fbl_q    <= '0;
				rows_q   <= '0;
				rbl_q    <= '0;
				pix_q    <= '0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= n_phase;
				shift_q  <= n_shift;
				hcnt_q   <= n_hcnt;
				frames_q <= n_frames;
				fbl_q    <= n_fbl;
				rows_q   <= n_rows;
				rbl_q    <= n_rbl;
				pix_q    <= n_pix;
				err_q    <= n_err;
			end
		end
	end

endmodule

### hw/rtl/rtpc_checker.sv
// Port-level checks for the transition payload checker, bound to the top level.
// Depends on rle_transition_payload_checker_unit.

module rtpc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               is_last,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               payload_valid
);

	// a stalled verdict beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(payload_valid))
		else $error("verdict changed while stalled");

	// a fresh verdict must trace back to a last beat taken at the input
	a_verdict_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && is_last, 2))
		else $error("verdict without a last beat");

	// with the output empty the input never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind rle_transition_payload_checker_unit rtpc_checker u_rtpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.is_last       (is_last),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_valid (payload_valid)
);

### test/rle_transition_payload_checker_unit_test.sv
// Self-checking bench for rle_transition_payload_checker_unit: streams payload bytes,
// tracks the parse in a shadow model and compares every verdict beat against it.
// Depends on rtpc_pkg and the checker RTL.

module rle_transition_payload_checker_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAMES       = rtpc_pkg::FRAME_COUNT_DEF;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned BYTE_TARGET  = 720;

	// register slots with no register behind them
	localparam logic [rtpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [rtpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic [2:0] {
		MANGLE_NONE,
		MANGLE_TRUNCATE,
		MANGLE_FLIP,
		MANGLE_TRAILER,
		MANGLE_NOISE
	} mangle_t;

	typedef struct {
		bit                             is_cfg;
		logic [rtpc_pkg::DATA_W-1:0]    data;
		logic                           last;
		logic [rtpc_pkg::CFG_IDX_W-1:0] idx;
		logic [rtpc_pkg::DIM_W-1:0]     val;
	} stim_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [rtpc_pkg::DATA_W-1:0]    data_byte = '0;
	logic                           is_last   = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           payload_valid;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [rtpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rtpc_pkg::DIM_W-1:0]     cfg_data  = '0;

	rle_transition_payload_checker_unit #(
		.FRAME_COUNT(FRAMES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_valid(payload_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- shadow parser ----------------
	logic [rtpc_pkg::DIM_W-1:0]      sh_width;
	logic [rtpc_pkg::DIM_W-1:0]      sh_height;
	rtpc_pkg::rtpc_phase_t           sh_phase;
	logic [31:0]                     sh_hdr_acc;
	logic [1:0]                      sh_hdr_cnt;
	logic [6:0]                      sh_frames;
	logic [rtpc_pkg::FRAME_SZ_W-1:0] sh_frame_left;
	logic [15:0]                     sh_rows;
	logic [15:0]                     sh_row_left;
	logic [15:0]                     sh_pix_left;
	logic                            sh_bad;

	logic                  verdict_q[$];
	int unsigned           verdicts_owed;
	int unsigned           verdicts_seen;
	int unsigned           mismatches;

	function automatic void clear_shadow();
		sh_phase      = rtpc_pkg::PH_FRAME_HDR;
		sh_hdr_acc    = '0;
		sh_hdr_cnt    = '0;
		sh_frames     = '0;
		sh_frame_left = '0;
		sh_rows       = '0;
		sh_row_left   = '0;
		sh_pix_left   = '0;
		sh_bad        = 1'b0;
	endfunction

	// end of a row, or start of a frame body
	function automatic void close_row();
		if (sh_rows >= sh_height) begin
			if (sh_frame_left != 0) begin
				sh_bad = 1'b1;
				return;
			end
			sh_frames = sh_frames + 7'd1;
			sh_phase  = (sh_frames >= FRAMES) ? rtpc_pkg::PH_DONE : rtpc_pkg::PH_FRAME_HDR;
		end else begin
			sh_phase = rtpc_pkg::PH_ROW_HDR;
		end
	endfunction

	function automatic void close_token();
		if (sh_row_left == 0) begin
			sh_rows = sh_rows + 16'd1;
			close_row();
		end else if (sh_pix_left == 0) begin
			sh_bad = 1'b1;
		end else begin
			sh_phase = rtpc_pkg::PH_TOKEN;
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (sh_phase)
			rtpc_pkg::PH_FRAME_HDR: begin
				sh_hdr_acc = sh_hdr_acc | (32'(b) << (8 * sh_hdr_cnt));
				sh_hdr_cnt = sh_hdr_cnt + 2'd1;
				if (sh_hdr_cnt == 0) begin
					sh_frame_left = sh_hdr_acc;
					sh_hdr_acc    = '0;
					sh_rows       = '0;
					close_row();
				end
			end
			rtpc_pkg::PH_ROW_HDR: begin
				if (sh_frame_left == 0) begin
					sh_bad = 1'b1;
				end else begin
					sh_frame_left = sh_frame_left - 1;
					sh_hdr_acc    = sh_hdr_acc | (32'(b) << (8 * sh_hdr_cnt));
					sh_hdr_cnt    = sh_hdr_cnt + 2'd1;
					if (sh_hdr_cnt >= 2) begin
						sh_row_left = sh_hdr_acc[15:0];
						sh_hdr_acc  = '0;
						sh_hdr_cnt  = '0;
						if (32'(sh_row_left) > sh_frame_left) begin
							sh_bad = 1'b1;
						end else begin
							sh_pix_left = sh_width;
							close_token();
						end
					end
				end
			end
			rtpc_pkg::PH_TOKEN: begin
				if (sh_row_left == 0 || sh_frame_left == 0) begin
					sh_bad = 1'b1;
				end else begin
					sh_row_left   = sh_row_left - 16'd1;
					sh_frame_left = sh_frame_left - 1;
					if (b != 0) begin
						if (sh_pix_left != 0)
							sh_pix_left = sh_pix_left - 16'd1;
						close_token();
					end else if (sh_row_left == 0) begin
						sh_bad = 1'b1;
					end else begin
						sh_phase = rtpc_pkg::PH_SKIP;
					end
				end
			end
			rtpc_pkg::PH_SKIP: begin
				if (sh_row_left == 0 || sh_frame_left == 0) begin
					sh_bad = 1'b1;
				end else begin
					sh_row_left   = sh_row_left - 16'd1;
					sh_frame_left = sh_frame_left - 1;
					if (b == 0 || 16'(b) > sh_pix_left) begin
						sh_bad = 1'b1;
					end else begin
						sh_pix_left = sh_pix_left - 16'(b);
						close_token();
					end
				end
			end
			default: sh_bad = 1'b1;
		endcase
	endfunction

	function automatic void track_beat(input logic [7:0] b, input logic last);
		if (!sh_bad)
			parse_byte(b);
		if (last) begin
			verdict_q = {verdict_q, (!sh_bad && sh_phase == rtpc_pkg::PH_DONE)};
			verdicts_owed++;
			clear_shadow();
		end
	endfunction

	function automatic void track_config(input logic [rtpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtpc_pkg::DIM_W-1:0] val);
		case (idx)
			rtpc_pkg::CFG_FRAME_WIDTH:  sh_width  = val;
			rtpc_pkg::CFG_FRAME_HEIGHT: sh_height = val;
			default: ;
		endcase
	endfunction

	// ---------------- stimulus store ----------------
	stim_t       stim_q[$];
	logic [7:0]  pl_buf[$];
	int unsigned gen_w;
	int unsigned gen_h;
	int unsigned gen_bytes;

	task automatic push_cfg(input logic [rtpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtpc_pkg::DIM_W-1:0] val);
		stim_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.val    = val;
		stim_q   = {stim_q, s};
		if (idx == rtpc_pkg::CFG_FRAME_WIDTH)
			gen_w = val;
		else if (idx == rtpc_pkg::CFG_FRAME_HEIGHT)
			gen_h = val;
	endtask

	task automatic send_payload();
		stim_t s;
		s = '{default: '0};
		foreach (pl_buf[i]) begin
			s.data = pl_buf[i];
			s.last = (i == pl_buf.size() - 1);
			stim_q = {stim_q, s};
		end
		gen_bytes += pl_buf.size();
	endtask

	// well-formed payload for the current width and height
	task automatic build_payload();
		logic [7:0]  body[$];
		logic [7:0]  row[$];
		int unsigned budget;
		int unsigned n;
		int unsigned skip;
		int unsigned f;
		int unsigned r;
		int unsigned t;
		pl_buf.delete();
		for (f = 0; f < FRAMES; f++) begin
			body.delete();
			for (r = 0; r < gen_h; r++) begin
				row.delete();
				budget = gen_w;
				n      = $urandom_range(0, 5);
				for (t = 0; t < n && budget != 0; t++) begin
					if ($urandom_range(0, 1) == 1) begin
						row = {row, 8'($urandom_range(1, 255))};
						budget--;
					end else begin
						skip = $urandom_range(1, (budget > 255) ? 255 : budget);
						row = {row, 8'h00, 8'(skip)};
						budget -= skip;
					end
				end
				body = {body, 8'(row.size()), 8'(row.size() >> 8)};
				foreach (row[i])
					body = {body, row[i]};
			end
			for (t = 0; t < 4; t++)
				pl_buf = {pl_buf, 8'(body.size() >> (8 * t))};
			foreach (body[i])
				pl_buf = {pl_buf, body[i]};
		end
	endtask

	task automatic mangle_payload(input mangle_t how);
		int unsigned k;
		case (how)
			MANGLE_TRUNCATE: begin
				if (pl_buf.size() > 1) begin
					k = $urandom_range(1, pl_buf.size() - 1);
					repeat (k) void'(pl_buf.pop_back());
				end
			end
			MANGLE_FLIP: begin
				k = $urandom_range(0, pl_buf.size() - 1);
				pl_buf[k] = pl_buf[k] ^ 8'($urandom_range(1, 255));
			end
			MANGLE_TRAILER: begin
				repeat ($urandom_range(1, 4)) pl_buf = {pl_buf, 8'($urandom_range(0, 255))};
			end
			MANGLE_NOISE: begin
				pl_buf.delete();
				repeat ($urandom_range(1, 20)) pl_buf = {pl_buf, 8'($urandom_range(0, 255))};
			end
			default: ;
		endcase
	endtask

	function automatic int unsigned pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)  return 0;
		if (r < 20) return 1;
		if (r < 60) return $urandom_range(2, 8);
		if (r < 85) return $urandom_range(9, 300);
		if (r < 93) return 16'hFFFF;
		return $urandom_range(0, 16'hFFFF);
	endfunction

	function automatic int unsigned pick_height();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return 0;
		if (r < 50) return 1;
		if (r < 80) return 2;
		if (r < 95) return 3;
		return $urandom_range(4, 6);
	endfunction

	// ---------------- byte and register driver ----------------
	int unsigned gap_left;
	int unsigned calm_left;
	int unsigned quiet_cycles;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(30, 80);
			return 0;
		end
		if (r < 65) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic  hold_in;
		logic  hold_cfg;
		stim_t s;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			cfg_valid     <= 1'b0;
			data_byte     <= '0;
			is_last       <= 1'b0;
			cfg_index     <= '0;
			cfg_data      <= '0;
			gap_left      = 0;
			calm_left     = 0;
			quiet_cycles  = 0;
			verdicts_owed = 0;
			verdict_q.delete();
			sh_width      = 16'd1;
			sh_height     = 16'd1;
			clear_shadow();
		end else begin
			if (in_valid && in_ready)
				track_beat(data_byte, is_last);
			if (cfg_valid && cfg_ready)
				track_config(cfg_index, cfg_data);
			hold_in  = in_valid && !in_ready;
			hold_cfg = cfg_valid && !cfg_ready;
			// verdicts_seen is updated nonblocking, so this sees last cycle's count
			if (!in_valid && verdicts_seen == verdicts_owed)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!hold_in && !hold_cfg) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (stim_q.size() != 0) begin
					if (!stim_q[0].is_cfg) begin
						s = stim_q.pop_front();
						data_byte <= s.data;
						is_last   <= s.last;
						hold_in   = 1'b1;
						gap_left  = pick_gap();
					end else if (quiet_cycles >= SETTLE) begin
						s = stim_q.pop_front();
						cfg_index <= s.idx;
						cfg_data  <= s.val;
						hold_cfg  = 1'b1;
						gap_left  = pick_gap();
					end
				end
			end
			in_valid  <= hold_in;
			cfg_valid <= hold_cfg;
		end
	end

	// ---------------- verdict monitor ----------------
	int unsigned ready_hold;

	always @(posedge clk or negedge arst_n) begin
		logic        want;
		int unsigned r;
		if (!arst_n) begin
			out_ready     <= 1'b0;
			verdicts_seen <= 0;
			ready_hold    = 0;
		end else begin
			if (out_valid && out_ready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdict_q.size() == 0) begin
					$error("payload_valid: beat with nothing expected, got %0b", payload_valid);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (payload_valid !== want) begin
						$error("payload_valid: expected %0b, got %0b", want, payload_valid);
						mismatches++;
					end
				end
			end
			if (ready_hold != 0) begin
				ready_hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready  <= 1'b1;
					ready_hold = $urandom_range(1, 20);
				end else begin
					out_ready  <= 1'b0;
					if (r < 90)
						ready_hold = $urandom_range(0, 2);
					else if (r < 97)
						ready_hold = $urandom_range(3, 14);
					else
						ready_hold = $urandom_range(30, 60);
				end
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		mangle_t how;
		int unsigned r;
		mismatches   = 0;
		gen_w        = 1;
		gen_h        = 1;
		gen_bytes    = 0;

		// zero height: empty frames, then a stray byte after the last frame
		push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'h0000);
		pl_buf = {};
		repeat (4 * FRAMES) pl_buf = {pl_buf, 8'h00};
		pl_buf = {pl_buf, 8'hFF};
		send_payload();
		// zero height with a nonzero frame size
		pl_buf = {8'h01, 8'h00, 8'h00, 8'h00};
		send_payload();
		// largest sizes, cut short after a max skip and a token
		push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
		push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
		pl_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'hFF, 8'h7F};
		send_payload();
		// zero width needs an empty row; byte after the error is ignored
		push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'h0000);
		push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'h0001);
		pl_buf = {8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h05};
		send_payload();
		// unused register slots must not disturb anything
		push_cfg(CFG_SPARE_A, 16'hFFFF);
		push_cfg(CFG_SPARE_B, 16'h0000);
		// width 1: pixels run out while row bytes remain
		push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'h0001);
		pl_buf = {8'h04, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h05, 8'h06};
		send_payload();

		gen_bytes = 0;
		while (gen_bytes < BYTE_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(0, 9);
				if (r < 4)
					push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'(pick_width()));
				else if (r < 8)
					push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'(pick_height()));
				else
					push_cfg(r[0] ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom_range(0, 16'hFFFF)));
			end
			build_payload();
			r = $urandom_range(0, 99);
			if (r < 60)      how = MANGLE_NONE;
			else if (r < 72) how = MANGLE_TRUNCATE;
			else if (r < 86) how = MANGLE_FLIP;
			else if (r < 94) how = MANGLE_TRAILER;
			else             how = MANGLE_NOISE;
			mangle_payload(how);
			send_payload();
		end
		// finish on the extremes of the width register
		push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
		push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'h0001);
		build_payload();
		send_payload();
		push_cfg(rtpc_pkg::CFG_FRAME_WIDTH, 16'h0000);
		push_cfg(rtpc_pkg::CFG_FRAME_HEIGHT, 16'h0002);
		build_payload();
		send_payload();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sample away from the driving edge so pending updates have landed
		@(negedge clk);
		while (stim_q.size() != 0 || in_valid || cfg_valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("rle_transition_payload_checker_unit test passed");
		else
			$display("rle_transition_payload_checker_unit test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("rle_transition_payload_checker_unit test failed");
		$finish;
	end

endmodule
